FILE: rtl/heartbeat_watchdog_power_cycler_top_assert.svh
// Assertion macros used by the watchdog core.
`ifndef HEARTBEAT_WATCHDOG_POWER_CYCLER_TOP_ASSERT_SVH
`define HEARTBEAT_WATCHDOG_POWER_CYCLER_TOP_ASSERT_SVH

// Condition must hold at every rising clock edge outside reset.
`define HWPC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define HWPC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hwpc_pkg.sv
// ----------------------------------------------------------------------------
// hwpc_pkg
// Types, codes and register defaults of the heartbeat watchdog power cycler.
// ----------------------------------------------------------------------------
package hwpc_pkg;

   localparam int CNT_W     = 16;
   localparam int REG_IDX_W = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_MISS_LIMIT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SHUTDOWN_TICK = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_POWERON_TICK  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_RESTART_TICKS = 3'd4;

   // register defaults
   localparam logic [CNT_W-1:0] DEF_MISS_LIMIT    = 16'd120;
   localparam logic [CNT_W-1:0] DEF_SETTLE_TICKS  = 16'd2;
   localparam logic [CNT_W-1:0] DEF_SHUTDOWN_TICK = 16'd120;
   localparam logic [CNT_W-1:0] DEF_POWERON_TICK  = 16'd160;
   localparam logic [CNT_W-1:0] DEF_RESTART_TICKS = 16'd40;

   // operation codes
   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_HEARTBEAT = 1'b1;

   // pulse commands
   localparam logic [1:0] PULSE_NONE    = 2'd0;
   localparam logic [1:0] PULSE_RESET3  = 2'd1;
   localparam logic [1:0] PULSE_RESTART = 2'd2;

   // phase codes
   localparam logic [1:0] PHASE_MONITOR   = 2'd0;
   localparam logic [1:0] PHASE_SETTLE    = 2'd1;
   localparam logic [1:0] PHASE_COUNTDOWN = 2'd2;
   localparam logic [1:0] PHASE_RESTART   = 2'd3;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   typedef struct packed {
      logic [CNT_W-1:0] miss_limit;
      logic [CNT_W-1:0] settle_ticks;
      logic [CNT_W-1:0] shutdown_tick;
      logic [CNT_W-1:0] poweron_tick;
      logic [CNT_W-1:0] restart_ticks;
   } cfg_type;

   typedef struct packed {
      logic operation;
      logic supply_on;
   } item_type;

   typedef struct packed {
      logic             startup;
      logic             settle;
      logic             countdown;
      logic             restart;
      logic [CNT_W-1:0] miss_cnt;
      logic [CNT_W-1:0] settle_cnt;
      logic [CNT_W-1:0] countdown_cnt;
      logic [CNT_W-1:0] restart_cnt;
      logic             relay;
      logic             report;
      logic             blink;
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] miss_count;
      logic             in_startup;
      logic [1:0]       phase;
      logic             blink_level;
      logic             report_level;
      logic [1:0]       pulse_command;
      logic             relay_level;
   } result_type;

endpackage

FILE: rtl/hwpc_cfg.sv
// ----------------------------------------------------------------------------
// hwpc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hwpc_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [hwpc_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [hwpc_pkg::CNT_W-1:0]      csr_wdata,
   output hwpc_pkg::cfg_type               cfg
);

   hwpc_pkg::cfg_type cfg_ff;
   hwpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            hwpc_pkg::REG_MISS_LIMIT:    cfg_in.miss_limit    = csr_wdata;
            hwpc_pkg::REG_SETTLE_TICKS:  cfg_in.settle_ticks  = csr_wdata;
            hwpc_pkg::REG_SHUTDOWN_TICK: cfg_in.shutdown_tick = csr_wdata;
            hwpc_pkg::REG_POWERON_TICK:  cfg_in.poweron_tick  = csr_wdata;
            hwpc_pkg::REG_RESTART_TICKS: cfg_in.restart_ticks = csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.miss_limit    <= hwpc_pkg::DEF_MISS_LIMIT;
         cfg_ff.settle_ticks  <= hwpc_pkg::DEF_SETTLE_TICKS;
         cfg_ff.shutdown_tick <= hwpc_pkg::DEF_SHUTDOWN_TICK;
         cfg_ff.poweron_tick  <= hwpc_pkg::DEF_POWERON_TICK;
         cfg_ff.restart_ticks <= hwpc_pkg::DEF_RESTART_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/hwpc_core.sv
// ----------------------------------------------------------------------------
// hwpc_core
// Supervisor state and the single-pass update for one tick or heartbeat.
// ----------------------------------------------------------------------------
`include "heartbeat_watchdog_power_cycler_top_assert.svh"

module hwpc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  hwpc_pkg::item_type    item,
   input  hwpc_pkg::cfg_type     cfg,
   output hwpc_pkg::result_type  result
);

   hwpc_pkg::state_type state_ff;
   hwpc_pkg::state_type state_in;
   logic [1:0]          pulse;
   logic [1:0]          phase;

   always_comb begin
      state_in = state_ff;
      pulse    = hwpc_pkg::PULSE_NONE;
      if (item.operation == hwpc_pkg::OP_HEARTBEAT) begin
         state_in.startup = 1'b0;
         if (!state_in.settle && !state_in.countdown) begin
            state_in.miss_cnt = '0;
         end
      end else begin
         state_in.blink = ~state_in.blink;
         // host unpowered while starting up: nothing to miss yet
         if (state_in.startup && !item.supply_on) begin
            state_in.miss_cnt = '0;
         end
         if (state_in.miss_cnt > cfg.miss_limit && !state_in.settle && !state_in.countdown) begin
            pulse               = hwpc_pkg::PULSE_RESET3;
            state_in.relay      = 1'b1;
            state_in.settle     = 1'b1;
            state_in.settle_cnt = '0;
         end
         if (state_in.settle) begin
            state_in.settle_cnt = state_in.settle_cnt + 1'b1;
            if (state_in.settle_cnt > cfg.settle_ticks) begin
               state_in.settle        = 1'b0;
               state_in.restart       = 1'b0;
               state_in.countdown     = 1'b1;
               state_in.miss_cnt      = '0;
               state_in.countdown_cnt = '0;
            end
         end else if (state_in.countdown) begin
            state_in.countdown_cnt = state_in.countdown_cnt + 1'b1;
            if (state_in.countdown_cnt == cfg.shutdown_tick) begin
               state_in.relay = 1'b0;
            end
            // equal ticks: relay ends high
            if (state_in.countdown_cnt == cfg.poweron_tick) begin
               state_in.relay       = 1'b1;
               pulse                = hwpc_pkg::PULSE_RESTART;
               state_in.restart     = 1'b1;
               state_in.restart_cnt = '0;
               state_in.report      = 1'b0;
            end
            if (state_in.restart) begin
               state_in.restart_cnt = state_in.restart_cnt + 1'b1;
               if (state_in.restart_cnt > cfg.restart_ticks) begin
                  state_in.report        = 1'b1;
                  state_in.restart       = 1'b0;
                  state_in.countdown     = 1'b0;
                  state_in.startup       = 1'b1;
                  state_in.countdown_cnt = '0;
                  state_in.restart_cnt   = '0;
               end
            end
         end else begin
            state_in.miss_cnt = state_in.miss_cnt + 1'b1;
         end
      end
   end

   always_comb begin
      priority if (state_in.settle) begin
         phase = hwpc_pkg::PHASE_SETTLE;
      end else if (state_in.countdown) begin
         phase = state_in.restart ? hwpc_pkg::PHASE_RESTART : hwpc_pkg::PHASE_COUNTDOWN;
      end else begin
         phase = hwpc_pkg::PHASE_MONITOR;
      end
   end

   always_comb begin
      result.relay_level   = state_in.relay;
      result.pulse_command = pulse;
      result.report_level  = state_in.report;
      result.blink_level   = state_in.blink;
      result.phase         = phase;
      result.in_startup    = state_in.startup;
      result.miss_count    = state_in.miss_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.startup       <= 1'b1;
         state_ff.settle        <= 1'b0;
         state_ff.countdown     <= 1'b0;
         state_ff.restart       <= 1'b0;
         state_ff.miss_cnt      <= '0;
         state_ff.settle_cnt    <= '0;
         state_ff.countdown_cnt <= '0;
         state_ff.restart_cnt   <= '0;
         state_ff.relay         <= 1'b1;
         state_ff.report        <= 1'b1;
         state_ff.blink         <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   `HWPC_ASSERT_ALWAYS(a_settle_excl_countdown, clock, reset,
      !(state_ff.settle && state_ff.countdown), "settle and countdown both active")
   `HWPC_ASSERT_ALWAYS(a_restart_in_countdown, clock, reset,
      !state_ff.restart || state_ff.countdown, "restart wait outside countdown")
   `HWPC_ASSERT_ALWAYS(a_report_tracks_restart, clock, reset,
      state_ff.report == !state_ff.restart, "report line out of step with restart wait")
   // a zero restart wait may end in the same tick, so only the relay is checked
   `HWPC_ASSERT_IMPLY(a_restart_pulse_relay_on, clock, reset,
      step_en && pulse == hwpc_pkg::PULSE_RESTART, state_in.relay,
      "restart pulse without relay on")

endmodule

FILE: rtl/heartbeat_watchdog_power_cycler_top.sv
// A request is held in the input register, then in the result register; rsp_tvalid
// rises when the item moves on, which waits while a result is held with rsp_tready low.
// Throughput: one transaction per cycle while rsp_tready is not held low; the state
// update is a single pass of compares and 16-bit increments between the two registers.
// Reset (synchronous, active high) empties both stages, returns the
// supervisor to start-up mode and loads the register defaults.
// ----------------------------------------------------------------------------
// heartbeat_watchdog_power_cycler_top
// Heartbeat watchdog that pulses the host reset and power-cycles its relay.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_power_cycler_top (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hwpc_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [0] supply_on, rest zero
   input  logic                                req_tuser,  // [0] operation
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] relay_level, [2:1] pulse_command, [3] report_level, [4] blink_level,
   // [6:5] phase, [7] in_startup, [23:8] miss_count
   output logic [hwpc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                                csr_we,
   input  logic [hwpc_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [hwpc_pkg::CNT_W-1:0]          csr_wdata
);

   hwpc_pkg::cfg_type    cfg;
   hwpc_pkg::item_type   item_ff;
   hwpc_pkg::item_type   item_in;
   hwpc_pkg::result_type result;
   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [hwpc_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [hwpc_pkg::RSP_TDATA_W-1:0] rsp_data_in;
   logic                            advance;
   logic                            req_take;

   hwpc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hwpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // input stage moves into the result register when that slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in.operation = req_tuser;
      item_in.supply_on = req_tdata[0];
      in_valid_in       = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in      = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in       = {result.miss_count, result.in_startup, result.phase,
                           result.blink_level, result.report_level,
                           result.pulse_command, result.relay_level};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/tb_heartbeat_watchdog_power_cycler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heartbeat_watchdog_power_cycler_top
// Self-checking bench for the heartbeat watchdog power cycler. A short table
// walks the reset state, the reset-pulse, settle, countdown and restart
// sequence, and the equal-tick case. Random settings and well-formed tick
// runs follow, with idle gaps and stalls on both streams. Every result
// transaction is checked against the table's status where given, else an in-bench model.
// ----------------------------------------------------------------------------
module tb_heartbeat_watchdog_power_cycler_top;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int CNT_W       = hwpc_pkg::CNT_W;
   localparam int REG_IDX_W   = hwpc_pkg::REG_IDX_W;
   localparam int REQ_TDATA_W = hwpc_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = hwpc_pkg::RSP_TDATA_W;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 op;
      logic                 sup;
      logic [REG_IDX_W-1:0] idx;
      logic [CNT_W-1:0]     val;
      logic                 typed;
      hwpc_pkg::result_type status;
   } row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = hwpc_pkg::OP_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [REG_IDX_W-1:0]   csr_index  = '0;
   logic [CNT_W-1:0]       csr_wdata  = '0;

   int                    req_idle_pct = 0;
   int                    rsp_idle_pct = 0;
   int                    failures     = 0;
   int                    cycle_count  = 0;
   hwpc_pkg::cfg_type     limits;
   hwpc_pkg::state_type   wd;
   hwpc_pkg::result_type  pending_status[$];
   row_type               directed[$];

   heartbeat_watchdog_power_cycler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---- supervisor model ----
   task automatic advance_watchdog(input logic op, input logic sup,
                                   output hwpc_pkg::result_type r);
      logic [1:0] pulse;
      pulse = hwpc_pkg::PULSE_NONE;
      if (op == hwpc_pkg::OP_HEARTBEAT) begin
         wd.startup = 1'b0;
         if (!wd.settle && !wd.countdown) wd.miss_cnt = '0;
      end else begin
         wd.blink = ~wd.blink;
         // unpowered host in start-up mode never accumulates misses
         if (wd.startup && !sup) wd.miss_cnt = '0;
         if (wd.miss_cnt > limits.miss_limit && !wd.settle && !wd.countdown) begin
            pulse         = hwpc_pkg::PULSE_RESET3;
            wd.relay      = 1'b1;
            wd.settle     = 1'b1;
            wd.settle_cnt = '0;
         end
         if (wd.settle) begin
            wd.settle_cnt = wd.settle_cnt + 1'b1;
            if (wd.settle_cnt > limits.settle_ticks) begin
               wd.settle        = 1'b0;
               wd.restart       = 1'b0;
               wd.countdown     = 1'b1;
               wd.miss_cnt      = '0;
               wd.countdown_cnt = '0;
            end
         end else if (wd.countdown) begin
            // keeps running through the restart wait, wraps at 16 bits
            wd.countdown_cnt = wd.countdown_cnt + 1'b1;
            if (wd.countdown_cnt == limits.shutdown_tick) wd.relay = 1'b0;
            if (wd.countdown_cnt == limits.poweron_tick) begin
               wd.relay       = 1'b1;
               pulse          = hwpc_pkg::PULSE_RESTART;
               wd.restart     = 1'b1;
               wd.restart_cnt = '0;
               wd.report      = 1'b0;
            end
            if (wd.restart) begin
               wd.restart_cnt = wd.restart_cnt + 1'b1;
               if (wd.restart_cnt > limits.restart_ticks) begin
                  wd.report        = 1'b1;
                  wd.restart       = 1'b0;
                  wd.countdown     = 1'b0;
                  wd.startup       = 1'b1;
                  wd.countdown_cnt = '0;
                  wd.restart_cnt   = '0;
               end
            end
         end else begin
            wd.miss_cnt = wd.miss_cnt + 1'b1;
         end
      end
      r.relay_level   = wd.relay;
      r.pulse_command = pulse;
      r.report_level  = wd.report;
      r.blink_level   = wd.blink;
      if (wd.settle)         r.phase = hwpc_pkg::PHASE_SETTLE;
      else if (wd.countdown) r.phase = wd.restart ? hwpc_pkg::PHASE_RESTART
                                                  : hwpc_pkg::PHASE_COUNTDOWN;
      else                   r.phase = hwpc_pkg::PHASE_MONITOR;
      r.in_startup    = wd.startup;
      r.miss_count    = wd.miss_cnt;
   endtask

   // ---- stimulus ----
   function automatic row_type item_row(input logic op, input logic sup);
      row_type r;
      r      = '0;
      r.kind = ROW_ITEM;
      r.op   = op;
      r.sup  = sup;
      return r;
   endfunction

   function automatic row_type typed_row(input logic op, input logic sup,
                                         input hwpc_pkg::result_type s);
      row_type r;
      r        = item_row(op, sup);
      r.typed  = 1'b1;
      r.status = s;
      return r;
   endfunction

   function automatic row_type write_row(input logic [REG_IDX_W-1:0] idx,
                                         input logic [CNT_W-1:0] val);
      row_type r;
      r      = '0;
      r.kind = ROW_WRITE;
      r.idx  = idx;
      r.val  = val;
      return r;
   endfunction

   function automatic hwpc_pkg::result_type status_of(input logic [CNT_W-1:0] miss,
                                                      input logic startup,
                                                      input logic blink);
      hwpc_pkg::result_type s;
      s.miss_count    = miss;
      s.in_startup    = startup;
      s.phase         = hwpc_pkg::PHASE_MONITOR;
      s.blink_level   = blink;
      s.report_level  = 1'b1;
      s.pulse_command = hwpc_pkg::PULSE_NONE;
      s.relay_level   = 1'b1;
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] pick_setting(input int unsigned floor_val,
                                                     input int unsigned ceil_val);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return CNT_W'(floor_val);
      if (roll < 25) return '1;
      return CNT_W'($urandom_range(ceil_val, floor_val));
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_item(input logic op, input logic sup, input logic typed,
                            input hwpc_pkg::result_type typed_status);
      hwpc_pkg::result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-1){1'b0}}, sup};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_watchdog(op, sup, predicted);
      pending_status.push_back(typed ? typed_status : predicted);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_status.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      case (idx)
         hwpc_pkg::REG_MISS_LIMIT:    limits.miss_limit    = val;
         hwpc_pkg::REG_SETTLE_TICKS:  limits.settle_ticks  = val;
         hwpc_pkg::REG_SHUTDOWN_TICK: limits.shutdown_tick = val;
         hwpc_pkg::REG_POWERON_TICK:  limits.poweron_tick  = val;
         hwpc_pkg::REG_RESTART_TICKS: limits.restart_ticks = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CNT_W-1:0] miss, input logic [CNT_W-1:0] settle,
                            input logic [CNT_W-1:0] shutdown, input logic [CNT_W-1:0] poweron,
                            input logic [CNT_W-1:0] restart);
      logic [REG_IDX_W-1:0] junk_idx;
      junk_idx = hwpc_pkg::REG_RESTART_TICKS + REG_IDX_W'($urandom_range(3, 1));
      write_reg(hwpc_pkg::REG_MISS_LIMIT, miss);
      write_reg(hwpc_pkg::REG_SETTLE_TICKS, settle);
      write_reg(hwpc_pkg::REG_SHUTDOWN_TICK, shutdown);
      write_reg(hwpc_pkg::REG_POWERON_TICK, poweron);
      write_reg(hwpc_pkg::REG_RESTART_TICKS, restart);
      // unmapped index, must be dropped
      write_reg(junk_idx, CNT_W'($urandom));
   endtask

   // mostly uninterrupted tick runs so whole power cycles complete
   task automatic run_random(input int count);
      int   left, burst, roll, span;
      bit   paused;
      logic op, sup;
      span = int'(limits.miss_limit) + int'(limits.settle_ticks) +
             int'(limits.poweron_tick) + int'(limits.restart_ticks) + 4;
      if (span > 400) span = 400;
      left   = count;
      paused = 1'b0;
      while (left > 0) begin
         if (!paused && left <= count / 2) begin
            pause_until_drained();
            paused = 1'b1;
         end
         roll = $urandom_range(99);
         if (roll < 60)      burst = $urandom_range(span, 1);
         else if (roll < 75) burst = $urandom_range(3, 1);
         else                burst = $urandom_range(6, 1);
         repeat (burst) begin
            if (left > 0) begin
               if (roll < 60) begin
                  op  = hwpc_pkg::OP_TICK;
                  sup = $urandom_range(99) < 90;
               end else if (roll < 75) begin
                  op  = hwpc_pkg::OP_HEARTBEAT;
                  sup = $urandom_range(1) == 1;
               end else begin
                  op  = $urandom_range(1) == 1;
                  sup = $urandom_range(1) == 1;
               end
               send_item(op, sup, 1'b0, '0);
               left--;
            end
         end
      end
   endtask

   // ---- result checking ----
   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, actual %0d", name, want, seen);
         failures++;
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      hwpc_pkg::result_type want, seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (pending_status.size() == 0) begin
            $error("result transaction with no pending status");
            failures++;
         end else begin
            want = pending_status.pop_front();
            compare_field("relay_level", want.relay_level, seen.relay_level);
            compare_field("pulse_command", want.pulse_command, seen.pulse_command);
            compare_field("report_level", want.report_level, seen.report_level);
            compare_field("blink_level", want.blink_level, seen.blink_level);
            compare_field("phase", want.phase, seen.phase);
            compare_field("in_startup", want.in_startup, seen.in_startup);
            compare_field("miss_count", want.miss_count, seen.miss_count);
         end
      end
   end

   // ---- main sequence ----
   initial begin
      int ph;
      limits.miss_limit    = hwpc_pkg::DEF_MISS_LIMIT;
      limits.settle_ticks  = hwpc_pkg::DEF_SETTLE_TICKS;
      limits.shutdown_tick = hwpc_pkg::DEF_SHUTDOWN_TICK;
      limits.poweron_tick  = hwpc_pkg::DEF_POWERON_TICK;
      limits.restart_ticks = hwpc_pkg::DEF_RESTART_TICKS;
      wd         = '0;
      wd.startup = 1'b1;
      wd.relay   = 1'b1;
      wd.report  = 1'b1;

      // reset state, start-up exit, unpowered clear
      directed.push_back(typed_row(hwpc_pkg::OP_TICK, 1'b0, status_of(16'd1, 1'b1, 1'b1)));
      directed.push_back(typed_row(hwpc_pkg::OP_TICK, 1'b1, status_of(16'd2, 1'b1, 1'b0)));
      directed.push_back(typed_row(hwpc_pkg::OP_HEARTBEAT, 1'b1,
                                   status_of(16'd0, 1'b0, 1'b0)));
      directed.push_back(typed_row(hwpc_pkg::OP_TICK, 1'b0, status_of(16'd1, 1'b0, 1'b1)));
      directed.push_back(typed_row(hwpc_pkg::OP_HEARTBEAT, 1'b0,
                                   status_of(16'd0, 1'b0, 1'b1)));
      // shortest sequence; relay off and on in the same tick
      directed.push_back(write_row(hwpc_pkg::REG_MISS_LIMIT, 16'd1));
      directed.push_back(write_row(hwpc_pkg::REG_SETTLE_TICKS, 16'd1));
      directed.push_back(write_row(hwpc_pkg::REG_SHUTDOWN_TICK, 16'd2));
      directed.push_back(write_row(hwpc_pkg::REG_POWERON_TICK, 16'd2));
      directed.push_back(write_row(hwpc_pkg::REG_RESTART_TICKS, 16'd0));
      repeat (3) directed.push_back(item_row(hwpc_pkg::OP_TICK, 1'b1));
      // settle wait keeps misses
      directed.push_back(item_row(hwpc_pkg::OP_HEARTBEAT, 1'b1));
      repeat (3) directed.push_back(item_row(hwpc_pkg::OP_TICK, 1'b1));
      repeat (2) directed.push_back(item_row(hwpc_pkg::OP_TICK, 1'b0));
      // separate shutdown and power-on, visible restart wait
      directed.push_back(write_row(hwpc_pkg::REG_SHUTDOWN_TICK, 16'd3));
      directed.push_back(write_row(hwpc_pkg::REG_POWERON_TICK, 16'd5));
      directed.push_back(write_row(hwpc_pkg::REG_RESTART_TICKS, 16'd2));
      directed.push_back(write_row(hwpc_pkg::REG_RESTART_TICKS + REG_IDX_W'(1), 16'hFFFF));
      directed.push_back(item_row(hwpc_pkg::OP_HEARTBEAT, 1'b1));
      repeat (9) directed.push_back(item_row(hwpc_pkg::OP_TICK, 1'b1));
      directed.push_back(item_row(hwpc_pkg::OP_HEARTBEAT, 1'b0));
      repeat (2) directed.push_back(item_row(hwpc_pkg::OP_TICK, 1'b1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 28;
      rsp_idle_pct = 80;
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE) begin
            pause_until_drained();
            write_reg(directed[i].idx, directed[i].val);
         end else begin
            send_item(directed[i].op, directed[i].sup, directed[i].typed, directed[i].status);
         end
      end

      for (ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin
            req_idle_pct = 80;
            rsp_idle_pct = 28;
         end
         if (ph == 8) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         pause_until_drained();
         if (ph == 0)
            write_all(hwpc_pkg::DEF_MISS_LIMIT, hwpc_pkg::DEF_SETTLE_TICKS,
                      hwpc_pkg::DEF_SHUTDOWN_TICK, hwpc_pkg::DEF_POWERON_TICK,
                      hwpc_pkg::DEF_RESTART_TICKS);
         else if (ph == 5)
            write_all('1, '1, '1, '1, '1);
         else if (ph == 9)
            write_all(16'd1, 16'd0, 16'd1, 16'd1, 16'd0);
         else
            write_all(pick_setting(1, 6), pick_setting(0, 3), pick_setting(1, 8),
                      pick_setting(1, 10), pick_setting(0, 5));
         run_random(ph == 0 ? 400 : 120);
      end

      pause_until_drained();
      repeat (8) @(negedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hwpc_pkg.sv
rtl/hwpc_cfg.sv
rtl/hwpc_core.sv
rtl/heartbeat_watchdog_power_cycler_top.sv
tb/tb_heartbeat_watchdog_power_cycler_top.sv
